/* hdl/rsb_pkg.sv */
`timescale 1ns / 1ps
package rsb_pkg;

  // Record store
  localparam int unsigned SLOTS  = 16;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Item field widths
  localparam int unsigned SLOT_FIELD_W = 4;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned COUNT_W      = 8;
  localparam int unsigned ACTION_W     = 3;

  // Backoff datapath: delay in Q.8, bounded by the ceiling in Q.8
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned FACTOR_W = 16;
  localparam int unsigned DQ_W     = TIME_W + FRAC_W;
  localparam int unsigned PROD_W   = DQ_W + FACTOR_W;
  localparam int unsigned SHIFT_W  = PROD_W - FRAC_W;

  // Window threshold in ms: window_seconds * 1000
  localparam int unsigned WIN_W     = 16;
  localparam int unsigned THRESH_W  = TIME_W + 1;
  localparam int unsigned MS_PER_S  = 1000;

  // Queue between front and back; depth is a power of two
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Stream widths
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 48;

  // Restart policy codes (code 3 behaves as never)
  localparam logic [1:0] POL_NEVER   = 2'd0;
  localparam logic [1:0] POL_ALWAYS  = 2'd1;
  localparam logic [1:0] POL_ON_FAIL = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLICY  = 3'd0,
    REG_WINDOW  = 3'd1,
    REG_MAX     = 3'd2,
    REG_INITIAL = 3'd3,
    REG_FACTOR  = 3'd4,
    REG_CEILING = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    CMD_ARM  = 1'b0,
    CMD_EXIT = 1'b1
  } cmd_e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ARMED      = 3'd0,
    ACT_NO_RESTART = 3'd1,
    ACT_ESCALATED  = 3'd2,
    ACT_SUPPRESSED = 3'd3,
    ACT_SCHEDULED  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EVAL,
    BK_MUL,
    BK_CMP,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [1:0]          restart_policy;
    logic [WIN_W-1:0]    window_seconds;
    logic [COUNT_W-1:0]  restart_limit;
    logic [TIME_W-1:0]   backoff_initial;
    logic [FACTOR_W-1:0] backoff_factor;
    logic [TIME_W-1:0]   backoff_ceiling;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    cmd_e                    cmd;
    logic                    permit;   // arm: policy opens records; exit: restart wanted
    logic                    slot_ok;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [TIME_W-1:0]       now_ms;
  } item_t;

  typedef struct packed {
    action_e                 action;
    logic [TIME_W-1:0]       delay_ms;
    logic [COUNT_W-1:0]      attempt_count;
    logic [SLOT_FIELD_W-1:0] result_slot;
  } result_t;

endpackage

/* hdl/rsb_front.sv */
`timescale 1ns / 1ps
module rsb_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        policy_i,
  input  logic                              s_valid_i,
  output logic                              s_ready_o,
  input  logic [rsb_pkg::S_TDATA_W-1:0]     s_data_i,
  input  logic                              s_user_i,
  output logic                              push_o,
  output rsb_pkg::item_t                    item_o,
  input  logic                              q_full_i
);
  import rsb_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  accept;
  logic  failed;
  logic  open_ok;

  assign s_ready_o = !valid_q || !q_full_i;
  assign accept    = s_valid_i && s_ready_o;
  assign push_o    = valid_q && !q_full_i;
  assign item_o    = item_q;

  assign failed  = s_data_i[SLOT_FIELD_W];
  assign open_ok = (policy_i == POL_ALWAYS) || (policy_i == POL_ON_FAIL);

  // Classify: decide from policy whether the item may open or restart
  always_comb begin
    item_d         = item_q;
    item_d.cmd     = cmd_e'(s_user_i);
    item_d.slot    = s_data_i[SLOT_FIELD_W-1:0];
    item_d.now_ms  = s_data_i[SLOT_FIELD_W+1 +: TIME_W];
    item_d.slot_ok = 32'(item_d.slot) < SLOTS;
    if (item_d.cmd == CMD_ARM) begin
      item_d.permit = open_ok;
    end else begin
      item_d.permit = (policy_i == POL_ALWAYS) || ((policy_i == POL_ON_FAIL) && failed);
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

/* hdl/rsb_fifo.sv */
`timescale 1ns / 1ps
module rsb_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rsb_pkg::item_t item_i,
  output logic           full_o,
  output logic           valid_o,
  output rsb_pkg::item_t item_o,
  input  logic           pop_i
);
  import rsb_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* hdl/rsb_back.sv */
`timescale 1ns / 1ps
module rsb_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rsb_pkg::cfg_t    cfg_i,
  input  logic             q_valid_i,
  input  rsb_pkg::item_t   q_item_i,
  output logic             q_pop_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output rsb_pkg::result_t m_result_o
);
  import rsb_pkg::*;

  back_state_e state_q, state_d;
  item_t       cur_q, cur_d;
  result_t     res_q, res_d;
  result_t     out_q;
  logic        out_valid_q, out_valid_d;
  logic        load_out;

  logic [THRESH_W-1:0] thresh_q;
  logic [DQ_W-1:0]     d_q, d_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [COUNT_W-1:0]  iter_q, iter_d;

  // Restart records; armed is the only part with a reset value
  logic [SLOTS-1:0]   armed_q;
  logic [TIME_W-1:0]  ws_q  [SLOTS];
  logic [COUNT_W-1:0] cnt_q [SLOTS];
  logic               esc_q [SLOTS];

  logic [SLOT_W-1:0]  idx;
  logic               hit;
  logic [TIME_W-1:0]  elapsed;
  logic               expired;
  logic [COUNT_W-1:0] cnt_eff;
  logic               need_mul;
  logic [SHIFT_W-1:0] d_next;
  logic [SHIFT_W-1:0] cap;
  logic               cap_hit;
  logic               last_iter;

  logic               armed_we, armed_wd;
  logic               rec_we;
  logic [TIME_W-1:0]  ws_wd;
  logic [COUNT_W-1:0] cnt_wd;
  logic               esc_wd;

  assign idx     = SLOT_W'(cur_q.slot);
  assign hit     = cur_q.slot_ok && armed_q[idx];
  assign elapsed = cur_q.now_ms - ws_q[idx];
  assign expired = {1'b0, elapsed} >= thresh_q;
  assign cnt_eff = expired ? '0 : cnt_q[idx];
  assign need_mul = (cur_q.cmd == CMD_EXIT) && hit && cur_q.permit &&
                    (cnt_eff < cfg_i.restart_limit) && (cnt_eff != '0);

  assign d_next    = prod_q[PROD_W-1:FRAC_W];
  assign cap       = {{(SHIFT_W-DQ_W){1'b0}}, cfg_i.backoff_ceiling, {FRAC_W{1'b0}}};
  assign cap_hit   = d_next >= cap;
  assign last_iter = iter_q == COUNT_W'(1);

  assign load_out   = (state_q == BK_DONE) && (!out_valid_q || m_ready_i);
  assign m_valid_o  = out_valid_q;
  assign m_result_o = out_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (q_valid_i) state_d = BK_EVAL;
      BK_EVAL: state_d = need_mul ? BK_MUL : BK_DONE;
      BK_MUL:  state_d = BK_CMP;
      BK_CMP:  if (cap_hit || last_iter) state_d = BK_DONE; else state_d = BK_MUL;
      BK_DONE: if (load_out) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath and record updates
  always_comb begin
    q_pop_o  = 1'b0;
    cur_d    = cur_q;
    res_d    = res_q;
    d_d      = d_q;
    prod_d   = prod_q;
    iter_d   = iter_q;
    armed_we = 1'b0;
    armed_wd = armed_q[idx];
    rec_we   = 1'b0;
    ws_wd    = ws_q[idx];
    cnt_wd   = cnt_q[idx];
    esc_wd   = esc_q[idx];
    case (state_q)
      BK_IDLE: begin
        q_pop_o = q_valid_i;
        cur_d   = q_item_i;
      end
      BK_EVAL: begin
        res_d.result_slot   = cur_q.slot;
        res_d.delay_ms      = '0;
        res_d.attempt_count = '0;
        if (cur_q.cmd == CMD_ARM) begin
          res_d.action = ACT_ARMED;
          if (cur_q.slot_ok) begin
            if (!armed_q[idx] && cur_q.permit) begin
              armed_we = 1'b1;
              armed_wd = 1'b1;
              rec_we   = 1'b1;
              ws_wd    = cur_q.now_ms;
              cnt_wd   = '0;
              esc_wd   = 1'b0;
            end else if (armed_q[idx]) begin
              res_d.attempt_count = cnt_q[idx];
            end
          end
        end else begin
          res_d.action = ACT_NO_RESTART;
          if (hit && !cur_q.permit) begin
            // declined restart: drop the record
            armed_we = 1'b1;
            armed_wd = 1'b0;
          end else if (hit) begin
            rec_we = 1'b1;
            ws_wd  = expired ? cur_q.now_ms : ws_q[idx];
            cnt_wd = cnt_eff;
            res_d.attempt_count = cnt_eff;
            if (cnt_eff >= cfg_i.restart_limit) begin
              if (esc_q[idx]) begin
                res_d.action = ACT_SUPPRESSED;
              end else begin
                res_d.action = ACT_ESCALATED;
                esc_wd       = 1'b1;
              end
            end else begin
              res_d.action        = ACT_SCHEDULED;
              cnt_wd              = cnt_eff + 1'b1;
              res_d.attempt_count = cnt_eff + 1'b1;
              res_d.delay_ms      = cfg_i.backoff_initial;
              d_d                 = {cfg_i.backoff_initial, {FRAC_W{1'b0}}};
              iter_d              = cnt_eff;
            end
          end
        end
      end
      BK_MUL: begin
        prod_d = {{(PROD_W-DQ_W){1'b0}}, d_q} *
                 {{(PROD_W-FACTOR_W){1'b0}}, cfg_i.backoff_factor};
      end
      BK_CMP: begin
        if (cap_hit) begin
          res_d.delay_ms = cfg_i.backoff_ceiling;
        end else begin
          d_d    = d_next[DQ_W-1:0];
          iter_d = iter_q - 1'b1;
          res_d.delay_ms = d_next[DQ_W-1:FRAC_W];
        end
      end
      BK_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      armed_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (armed_we) begin
        armed_q[idx] <= armed_wd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    res_q    <= res_d;
    d_q      <= d_d;
    prod_q   <= prod_d;
    iter_q   <= iter_d;
    thresh_q <= {{(THRESH_W-WIN_W){1'b0}}, cfg_i.window_seconds} * THRESH_W'(MS_PER_S);
    if (load_out) begin
      out_q <= res_q;
    end
    if (rec_we) begin
      ws_q[idx]  <= ws_wd;
      cnt_q[idx] <= cnt_wd;
      esc_q[idx] <= esc_wd;
    end
  end

endmodule

/* hdl/restart_supervisor_backoff.sv */
`timescale 1ns / 1ps
// Channel  | Handshake                      | Words carried
// ---------+--------------------------------+-----------------------------------------------
// s_axis   | s_axis_tvalid / s_axis_tready  | one event: arm or exit of a slot
// m_axis   | m_axis_tvalid / m_axis_tready  | one result per event, in event order
// cfg      | cfg_we_i (no wait)             | policy, window, limit, backoff settings
//
// Backoff math runs one multiply step per restart already counted (up to 254)
// on the single shared 40x16 multiplier, and stops early at the ceiling.
// Reset clears all restart records (armed flags) and loads register defaults.
// The front stage and a two-word queue keep accepting while the back end
// iterates or the output word waits on m_axis_tready, until both are full.
module restart_supervisor_backoff (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [rsb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rsb_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // event input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rsb_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // slot[3:0], exit_failed[4], now_ms[36:5]
  input  logic                              s_axis_tuser,  // operation[0]
  // result output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rsb_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // delay_ms[31:0], attempt_count[39:32],
                                                           // result_slot[43:40]
  output logic [rsb_pkg::ACTION_W-1:0]      m_axis_tuser   // action[2:0]
);
  import rsb_pkg::*;

  cfg_t    cfg_q, cfg_d;
  logic    push;
  item_t   f_item;
  logic    q_full;
  logic    q_valid;
  item_t   q_item;
  logic    q_pop;
  result_t result;

  // Register file: hold values, write whole register on cfg_we_i
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POLICY:  cfg_d.restart_policy  = cfg_data_i[1:0];
        REG_WINDOW:  cfg_d.window_seconds  = cfg_data_i[WIN_W-1:0];
        REG_MAX:     cfg_d.restart_limit   = cfg_data_i[COUNT_W-1:0];
        REG_INITIAL: cfg_d.backoff_initial = cfg_data_i[TIME_W-1:0];
        REG_FACTOR:  cfg_d.backoff_factor  = cfg_data_i[FACTOR_W-1:0];
        REG_CEILING: cfg_d.backoff_ceiling = cfg_data_i[TIME_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.restart_policy  <= POL_NEVER;
      cfg_q.window_seconds  <= WIN_W'(60);
      cfg_q.restart_limit   <= COUNT_W'(5);
      cfg_q.backoff_initial <= TIME_W'(1000);
      cfg_q.backoff_factor  <= FACTOR_W'(512);
      cfg_q.backoff_ceiling <= TIME_W'(60000);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: accept and classify events
  rsb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .policy_i  (cfg_q.restart_policy),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .push_o    (push),
    .item_o    (f_item),
    .q_full_i  (q_full)
  );

  // Decoupling queue
  rsb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  // Back: update records, run backoff, drive output word
  rsb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_result_o (result)
  );

  assign m_axis_tdata = {4'b0, result.result_slot, result.attempt_count, result.delay_ms};
  assign m_axis_tuser = result.action;

endmodule

/* tb/tb_restart_supervisor_backoff.sv */
`timescale 1ns / 1ps
module tb_restart_supervisor_backoff;
  import rsb_pkg::*;

  // Code 3 of the policy register has no name in the package; it acts as never.
  localparam logic [1:0] POL_RESERVED = 2'd3;

  localparam int unsigned N_PLAN     = 42;
  localparam int unsigned N_PHASES   = 10;
  localparam int unsigned PHASE_LEN  = 95;
  // Longest event: up to 254 backoff multiplies.
  localparam int unsigned LATENCY_MAX = 4 + 2 * 254;

  // One line of the directed plan: either a register write or an event.
  // When has_want is set the expected word is typed in here; otherwise the
  // supervisor model below supplies it.
  typedef struct packed {
    logic       is_cfg;
    cfg_reg_e   reg_idx;
    logic [31:0] reg_val;
    cmd_e       op;
    logic [3:0] slot;
    logic       failed;
    logic [31:0] now;
    logic       has_want;
    result_t    want;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = REG_POLICY;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;  // slot[3:0], exit_failed[4], now_ms[36:5]
  logic                  s_axis_tuser = CMD_ARM;  // operation[0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;  // delay_ms[31:0], attempt_count[39:32],
                                        // result_slot[43:40]
  logic [ACTION_W-1:0]   m_axis_tuser;  // action[2:0]

  restart_supervisor_backoff DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Supervisor model: register copies, loaded with the reset defaults
  logic [1:0]  pol      = POL_NEVER;
  logic [15:0] win_s    = 16'd60;
  logic [7:0]  max_r    = 8'd5;
  logic [31:0] bo_init  = 32'd1000;
  logic [15:0] bo_fac   = 16'd512;
  logic [31:0] bo_ceil  = 32'd60000;

  // Supervisor model: per-slot restart records
  bit          rec_armed     [SLOTS];
  logic [31:0] rec_start     [SLOTS];
  logic [7:0]  rec_count     [SLOTS];
  bit          rec_escalated [SLOTS];

  // Result words owed by the block, oldest first
  result_t     due_results[$];

  plan_row_t   plan [N_PLAN];
  bit          calm = 1'b0;      // both sides stop idling while set
  logic [31:0] clock_ms = '0;    // running event time for the random part
  int          errors = 0;
  int          n_events = 0;
  int          n_plan_ev = 0;
  int          n_checked = 0;
  int          n_sched = 0;
  int          n_escal = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Delay for a record that has already restarted `count` times: multiply the
  // first delay in Q.8 once per restart, stop at the ceiling.
  function automatic logic [31:0] delay_for_count(logic [7:0] count);
    logic [63:0] d;
    logic [63:0] cap;
    if (count == 8'd0) return bo_init;
    d   = {24'd0, bo_init, 8'd0};
    cap = {24'd0, bo_ceil, 8'd0};
    for (int i = 0; i < count; i++) begin
      d = (d * {48'd0, bo_fac}) >> 8;
      if (d >= cap) return bo_ceil;
    end
    return d[39:8];
  endfunction

  // Apply one event to the model records and return the word it must produce.
  function automatic result_t decide_action(cmd_e op, logic [3:0] slot, logic failed,
                                            logic [31:0] now);
    result_t     r;
    logic        go;
    logic [31:0] elapsed_s;
    r.action        = ACT_NO_RESTART;
    r.delay_ms      = '0;
    r.attempt_count = '0;
    r.result_slot   = slot;
    if (op == CMD_ARM) begin
      r.action = ACT_ARMED;
      // open a record only when none exists and the policy can restart
      if (!rec_armed[slot] && (pol == POL_ALWAYS || pol == POL_ON_FAIL)) begin
        rec_armed[slot]     = 1'b1;
        rec_start[slot]     = now;
        rec_count[slot]     = '0;
        rec_escalated[slot] = 1'b0;
      end
      if (rec_armed[slot]) r.attempt_count = rec_count[slot];
    end else if (rec_armed[slot]) begin
      go = (pol == POL_ALWAYS) || (pol == POL_ON_FAIL && failed);
      if (!go) begin
        // declined restart drops the record
        rec_armed[slot] = 1'b0;
      end else begin
        // wrapping elapsed time, truncated to whole seconds
        elapsed_s = (now - rec_start[slot]) / 32'd1000;
        if (elapsed_s >= {16'd0, win_s}) begin
          rec_start[slot] = now;
          rec_count[slot] = '0;
        end
        if (rec_count[slot] >= max_r) begin
          // escalated flag survives window restarts: escalate once per record
          if (!rec_escalated[slot]) begin
            rec_escalated[slot] = 1'b1;
            r.action = ACT_ESCALATED;
          end else begin
            r.action = ACT_SUPPRESSED;
          end
        end else begin
          r.delay_ms      = delay_for_count(rec_count[slot]);
          rec_count[slot] = rec_count[slot] + 8'd1;
          r.action        = ACT_SCHEDULED;
        end
        r.attempt_count = rec_count[slot];
      end
    end
    return r;
  endfunction

  function automatic plan_row_t row_cfg(cfg_reg_e idx, logic [31:0] val);
    plan_row_t p;
    p = '0;
    p.is_cfg  = 1'b1;
    p.reg_idx = idx;
    p.reg_val = val;
    return p;
  endfunction

  function automatic plan_row_t row_ev(cmd_e op, logic [3:0] slot, logic failed,
                                       logic [31:0] now);
    plan_row_t p;
    p = '0;
    p.op     = op;
    p.slot   = slot;
    p.failed = failed;
    p.now    = now;
    return p;
  endfunction

  function automatic plan_row_t row_chk(cmd_e op, logic [3:0] slot, logic failed,
                                        logic [31:0] now, action_e act,
                                        logic [31:0] dly, logic [7:0] cnt);
    plan_row_t p;
    p = row_ev(op, slot, failed, now);
    p.has_want           = 1'b1;
    p.want.action        = act;
    p.want.delay_ms      = dly;
    p.want.attempt_count = cnt;
    p.want.result_slot   = slot;
    return p;
  endfunction

  // Write one register. Hold the enable for a single edge, then drop it.
  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_POLICY:  pol     = val[1:0];
      REG_WINDOW:  win_s   = val[15:0];
      REG_MAX:     max_r   = val[7:0];
      REG_INITIAL: bo_init = val;
      REG_FACTOR:  bo_fac  = val[15:0];
      REG_CEILING: bo_ceil = val;
      default: ;
    endcase
  endtask

  // Stop sending and wait until every owed word has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Offer one event word; keep tvalid high afterwards so a back-to-back word
  // needs no second assignment in the same step.
  task automatic send_event(cmd_e op, logic [3:0] slot, logic failed, logic [31:0] now,
                            logic has_want, result_t want);
    int      gap;
    result_t r;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, now, failed, slot};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = decide_action(op, slot, failed, now);
    if (has_want) r = want;
    due_results.insert(due_results.size(), r);
    n_events++;
  endtask

  // Draw a new setting for every register. Bias toward short windows, low
  // limits and factors near 1.0 to 4.0 so records cycle through all states;
  // keep some full-range draws.
  task automatic reconfigure();
    int          pick;
    logic [31:0] val;
    pick = $urandom_range(0, 99);
    if (pick < 45)      val = 32'(POL_ALWAYS);
    else if (pick < 80) val = 32'(POL_ON_FAIL);
    else if (pick < 90) val = 32'(POL_NEVER);
    else                val = 32'(POL_RESERVED);
    write_reg(REG_POLICY, val);
    pick = $urandom_range(0, 99);
    if (pick < 70)      val = $urandom_range(0, 20);
    else if (pick < 90) val = $urandom_range(0, 300);
    else                val = $urandom_range(0, 65535);
    write_reg(REG_WINDOW, val);
    pick = $urandom_range(0, 99);
    if (pick < 70)      val = $urandom_range(0, 8);
    else if (pick < 90) val = $urandom_range(0, 40);
    else                val = $urandom_range(0, 255);
    write_reg(REG_MAX, val);
    pick = $urandom_range(0, 99);
    if (pick < 60)      val = $urandom_range(1, 5000);
    else if (pick < 90) val = $urandom;
    else                val = '0;
    write_reg(REG_INITIAL, val);
    pick = $urandom_range(0, 99);
    if (pick < 60)      val = $urandom_range(256, 1024);
    else if (pick < 85) val = $urandom_range(0, 255);
    else                val = $urandom_range(0, 65535);
    write_reg(REG_FACTOR, val);
    pick = $urandom_range(0, 99);
    if (pick < 50)      val = $urandom_range(1000, 200000);
    else if (pick < 90) val = $urandom;
    else                val = '0;
    write_reg(REG_CEILING, val);
  endtask

  // One random event: mostly exits on a slot group (all, or a narrow run), time
  // moving forward in small steps, with jumps across the window and wild values.
  task automatic random_event(int span, logic [3:0] base);
    int          pick;
    cmd_e        op;
    logic [3:0]  slot;
    logic        failed;
    logic [31:0] win_ms;
    op     = ($urandom_range(0, 99) < 22) ? CMD_ARM : CMD_EXIT;
    slot   = base + 4'($urandom_range(0, span - 1));
    failed = 1'($urandom_range(0, 1));
    win_ms = {16'd0, win_s} * 32'd1000;
    pick   = $urandom_range(0, 99);
    if (pick < 70)      clock_ms = clock_ms + $urandom_range(0, 2500);
    else if (pick < 92) clock_ms = clock_ms + $urandom_range(0, 3 * win_ms + 1000);
    else                clock_ms = $urandom;
    send_event(op, slot, failed, clock_ms, 1'b0, '0);
  endtask

  // Result side: random stalls, then compare each word with the oldest owed one.
  initial begin : result_sink
    int      stall;
    result_t got;
    result_t want;
    wait (rst_ni === 1'b1);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got.action        = action_e'(m_axis_tuser);
      got.delay_ms      = m_axis_tdata[31:0];
      got.attempt_count = m_axis_tdata[39:32];
      got.result_slot   = m_axis_tdata[43:40];
      if (due_results.size() == 0) begin
        $error("unexpected result word: action %0d slot %0d", got.action, got.result_slot);
        errors++;
      end else begin
        want = due_results.pop_front();
        n_checked++;
        if (want.action == ACT_SCHEDULED) n_sched++;
        if (want.action == ACT_ESCALATED) n_escal++;
        if (got.action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, got.action);
          errors++;
        end
        if (got.delay_ms !== want.delay_ms) begin
          $error("delay_ms: expected %0d, got %0d", want.delay_ms, got.delay_ms);
          errors++;
        end
        if (got.attempt_count !== want.attempt_count) begin
          $error("attempt_count: expected %0d, got %0d", want.attempt_count,
                 got.attempt_count);
          errors++;
        end
        if (got.result_slot !== want.result_slot) begin
          $error("result_slot: expected %0d, got %0d", want.result_slot, got.result_slot);
          errors++;
        end
      end
    end
  end

  // Hard stop in case the block hangs or drops words.
  initial begin : watchdog
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int         span;
    logic [3:0] base;
    for (int s = 0; s < SLOTS; s++) begin
      rec_armed[s]     = 1'b0;
      rec_start[s]     = '0;
      rec_count[s]     = '0;
      rec_escalated[s] = 1'b0;
    end

    // Directed plan. Defaults: never, 60 s window, limit 5, 1000 ms, x2.0, 60000 ms.
    plan = '{
      // policy never at reset: arm opens nothing, exit finds no record
      row_chk(CMD_ARM,  4'd0,  1'b0, 32'd0,     ACT_ARMED,      32'd0,     8'd0),
      row_chk(CMD_EXIT, 4'd0,  1'b1, 32'd10,    ACT_NO_RESTART, 32'd0,     8'd0),
      row_cfg(REG_POLICY, 32'(POL_ALWAYS)),
      // doubling backoff up to the limit, arm while armed keeps the count
      row_chk(CMD_ARM,  4'd0,  1'b0, 32'd0,     ACT_ARMED,      32'd0,     8'd0),
      row_chk(CMD_EXIT, 4'd0,  1'b0, 32'd1000,  ACT_SCHEDULED,  32'd1000,  8'd1),
      row_chk(CMD_EXIT, 4'd0,  1'b1, 32'd2000,  ACT_SCHEDULED,  32'd2000,  8'd2),
      row_chk(CMD_ARM,  4'd0,  1'b0, 32'd2500,  ACT_ARMED,      32'd0,     8'd2),
      row_chk(CMD_EXIT, 4'd0,  1'b0, 32'd3000,  ACT_SCHEDULED,  32'd4000,  8'd3),
      row_chk(CMD_EXIT, 4'd0,  1'b0, 32'd4000,  ACT_SCHEDULED,  32'd8000,  8'd4),
      row_chk(CMD_EXIT, 4'd0,  1'b0, 32'd5000,  ACT_SCHEDULED,  32'd16000, 8'd5),
      row_chk(CMD_EXIT, 4'd0,  1'b0, 32'd6000,  ACT_ESCALATED,  32'd0,     8'd5),
      // window runs out: count restarts, escalated flag stays
      row_chk(CMD_EXIT, 4'd0,  1'b0, 32'hFFFF_FFFF, ACT_SCHEDULED, 32'd1000, 8'd1),
      // time wraps through zero inside the window
      row_chk(CMD_ARM,  4'd15, 1'b0, 32'hFFFF_FFFF, ACT_ARMED,    32'd0,     8'd0),
      row_chk(CMD_EXIT, 4'd15, 1'b1, 32'h0000_1000, ACT_SCHEDULED, 32'd1000, 8'd1),
      row_cfg(REG_POLICY, 32'(POL_ON_FAIL)),
      // clean exit under on-failure drops the record
      row_chk(CMD_EXIT, 4'd15, 1'b0, 32'h0000_2000, ACT_NO_RESTART, 32'd0,   8'd0),
      row_cfg(REG_POLICY, 32'(POL_RESERVED)),
      // policy code 3 behaves as never
      row_chk(CMD_ARM,  4'd3,  1'b1, 32'd0,     ACT_ARMED,      32'd0,     8'd0),
      row_chk(CMD_EXIT, 4'd0,  1'b1, 32'd10000, ACT_NO_RESTART, 32'd0,     8'd0),
      row_cfg(REG_POLICY, 32'(POL_ALWAYS)),
      row_cfg(REG_MAX, 32'd0),
      row_cfg(REG_WINDOW, 32'd0),
      // zero limit with zero window: escalate, then suppress
      row_chk(CMD_ARM,  4'd7,  1'b0, 32'd100,   ACT_ARMED,      32'd0,     8'd0),
      row_chk(CMD_EXIT, 4'd7,  1'b0, 32'd100,   ACT_ESCALATED,  32'd0,     8'd0),
      row_chk(CMD_EXIT, 4'd7,  1'b1, 32'd200,   ACT_SUPPRESSED, 32'd0,     8'd0),
      row_cfg(REG_MAX, 32'd255),
      row_cfg(REG_WINDOW, 32'd65535),
      row_cfg(REG_INITIAL, 32'hFFFF_FFFF),
      row_cfg(REG_FACTOR, 32'h0000_FFFF),
      row_cfg(REG_CEILING, 32'hFFFF_FFFF),
      // all-ones settings: first delay as is, next one clamps at the ceiling
      row_chk(CMD_ARM,  4'd8,  1'b0, 32'd0,     ACT_ARMED,      32'd0,     8'd0),
      row_chk(CMD_EXIT, 4'd8,  1'b1, 32'd1,     ACT_SCHEDULED,  32'hFFFF_FFFF, 8'd1),
      row_chk(CMD_EXIT, 4'd8,  1'b0, 32'd2,     ACT_SCHEDULED,  32'hFFFF_FFFF, 8'd2),
      row_cfg(REG_FACTOR, 32'd0),
      row_ev(CMD_EXIT,  4'd8,  1'b1, 32'd3),
      row_cfg(REG_INITIAL, 32'd9000),
      row_cfg(REG_CEILING, 32'd5000),
      row_cfg(REG_FACTOR, 32'd384),
      // first delay above the ceiling passes unchanged; the next one is capped
      row_chk(CMD_ARM,  4'd9,  1'b0, 32'd0,     ACT_ARMED,      32'd0,     8'd0),
      row_chk(CMD_EXIT, 4'd9,  1'b1, 32'd1,     ACT_SCHEDULED,  32'd9000,  8'd1),
      row_chk(CMD_EXIT, 4'd9,  1'b1, 32'd2,     ACT_SCHEDULED,  32'd5000,  8'd2),
      row_ev(CMD_EXIT,  4'd9,  1'b0, 32'd3)
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Walk the plan; register writes wait for the block to go idle.
    for (int i = 0; i < N_PLAN; i++) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_event(plan[i].op, plan[i].slot, plan[i].failed, plan[i].now,
                   plan[i].has_want, plan[i].want);
        n_plan_ev++;
      end
    end

    // Random phases, each under a fresh setting. Every third phase runs
    // without idling on either side.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      drain();
      reconfigure();
      calm = (phase % 3 == 1);
      span = ($urandom_range(0, 1) == 0) ? 16 : $urandom_range(1, 4);
      base = 4'($urandom_range(0, 15));
      for (int k = 0; k < PHASE_LEN; k++) random_event(span, base);
    end

    // Let everything owed come back, then watch for stray words.
    calm = 1'b0;
    drain();
    repeat (LATENCY_MAX) @(posedge clk_i);

    $display("summary: %0d events (%0d from the directed plan), %0d results checked,",
             n_events, n_plan_ev, n_checked);
    $display("summary: %0d restarts scheduled, %0d escalations, %0d mismatches",
             n_sched, n_escal, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* restart_supervisor_backoff.f */
hdl/rsb_pkg.sv
hdl/rsb_front.sv
hdl/rsb_fifo.sv
hdl/rsb_back.sv
hdl/restart_supervisor_backoff.sv
tb/tb_restart_supervisor_backoff.sv
